>>> rtl/drs_pkg.sv
// drs_pkg: shared types and constants of the disk request scheduler.
// No dependencies.
`timescale 1ns / 1ps
package drs_pkg;

  localparam int DRS_MAX_REQUESTS = 32;
  localparam int DRS_TOP_TRACK    = 1023;

  localparam int TRACK_W  = 10;
  localparam int POS_W    = 16;   // head position and seek distance
  localparam int MOVE_W   = 16;
  localparam int IDX_W    = 6;    // enough for 64 cells
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SSTF  = 2'd1,
    POL_SCAN  = 2'd2,
    POL_CSCAN = 2'd3
  } policy_t;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TRACK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 2'd2;

  // best candidate so far, handed from cell to cell
  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   key;
    logic [IDX_W-1:0]   idx;
    logic [TRACK_W-1:0] track;
  } token_t;

endpackage

>>> rtl/drs_cell.sv
// drs_cell: one request slot of the scheduler chain plus its compare stage.
// Depends on drs_pkg.
`timescale 1ns / 1ps
module drs_cell import drs_pkg::*; #(
  parameter int CELL_INDEX = 0,
  parameter int CNT_W      = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load_en,
  input  logic [TRACK_W-1:0] load_track,
  input  logic [CNT_W-1:0]   count,
  input  logic               clr,
  input  logic               mark_en,
  input  logic [IDX_W-1:0]   mark_idx,
  input  logic [POS_W-1:0]   head,
  input  policy_t            policy,
  input  logic               up,
  input  token_t             tok_in,
  output token_t             tok_out
);

  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

  logic [TRACK_W-1:0] track_r;
  logic               served_r;
  token_t             tok_r;

  logic [POS_W-1:0] t_ext;
  logic [POS_W-1:0] seek_dist;
  logic [POS_W-1:0] key;
  logic             in_dir;
  logic             eligible;
  logic             better;

  always_comb begin
    t_ext  = POS_W'(track_r);
    seek_dist = (t_ext > head) ? (t_ext - head) : (head - t_ext);
    in_dir = up ? (t_ext >= head) : (t_ext <= head);
    eligible = (MY_CNT < count) && !served_r &&
               ((policy == POL_FCFS) || (policy == POL_SSTF) || in_dir);
    key    = (policy == POL_FCFS) ? '0 : seek_dist;
    better = eligible && (!tok_in.found || (key < tok_in.key));
  end

  always_ff @(posedge clk) begin
    if (load_en && (count == MY_CNT)) begin
      track_r <= load_track;
    end
    if (better) begin
      tok_r <= '{found: 1'b1, key: key, idx: MY_IDX, track: track_r};
    end else begin
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      served_r <= 1'b0;
    end else if (clr || (load_en && (count == MY_CNT))) begin
      served_r <= 1'b0;
    end else if (mark_en && (mark_idx == MY_IDX)) begin
      served_r <= 1'b1;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> rtl/disk_request_scheduler_top.sv
// Disk request scheduler: loads one request per cycle while idle, then serves the batch.
// Scheduling: a beat with last_request starts it; each served request and each
// SCAN/C-SCAN edge run takes a chain pass in the search state, then a decide state.
// Loading runs at one beat a cycle while idle; busy stays high until the final result beat.
// Reset: synchronous active-low rst_n clears control, counts, marks and configuration.
// Results appear for one cycle on out_valid; the receiver cannot stall. Uses drs_cell.
`timescale 1ns / 1ps
module disk_request_scheduler_top import drs_pkg::*; #(
  parameter int MAX_REQUESTS = DRS_MAX_REQUESTS,
  parameter int TOP_TRACK    = DRS_TOP_TRACK
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // request beats
  input  logic                  start,
  output logic                  busy,
  input  logic [TRACK_W-1:0]    in_track,
  input  logic                  in_last_request,
  // result beats
  output logic                  out_valid,
  output logic [TRACK_W-1:0]    out_served_track,
  output logic [MOVE_W-1:0]     out_movement_so_far,
  output logic                  out_final_result,
  output logic                  out_overflowed
);

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_REQUESTS);
  localparam logic [CNT_W-1:0] SRCH_END = CNT_W'(MAX_REQUESTS - 1);
  localparam logic [POS_W-1:0] TOP_POS  = POS_W'(TOP_TRACK);
  localparam logic [MOVE_W+1:0] MOVE_SAT = {2'b00, {MOVE_W{1'b1}}};

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  // configuration registers
  policy_t             policy_r;
  logic [TRACK_W-1:0]  start_track_r;
  logic                direction_up_r;

  // control
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    emitted_r, emitted_nxt;
  logic [CNT_W-1:0]    srch_r, srch_nxt;
  logic                ovf_r, ovf_nxt;
  logic                up_r, up_nxt;
  policy_t             pol_r, pol_nxt;
  logic [POS_W-1:0]    head_r, head_nxt;
  logic [MOVE_W-1:0]   move_r, move_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [TRACK_W-1:0]  out_track_r, out_track_nxt;
  logic [MOVE_W-1:0]   out_move_r, out_move_nxt;
  logic                out_final_r, out_final_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  // chain control
  logic                accept;
  logic                load_en;
  logic                clr;
  logic                mark_en;
  token_t              tok [0:MAX_REQUESTS];
  token_t              win;

  logic [POS_W-1:0]    seek;
  logic [MOVE_W+1:0]   sum;
  logic [CNT_W-1:0]    emitted_inc;

  assign accept  = start && (state_r == ST_IDLE);
  assign load_en = accept && (count_r != CNT_MAX);
  assign tok[0]  = '0;
  assign win     = tok[MAX_REQUESTS];
  assign emitted_inc = emitted_r + CNT_W'(1);

  // row of request cells; the best candidate ripples one cell per cycle
  for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
    drs_cell #(
      .CELL_INDEX (g),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .load_en    (load_en),
      .load_track (in_track),
      .count      (count_r),
      .clr        (clr),
      .mark_en    (mark_en),
      .mark_idx   (win.idx),
      .head       (head_r),
      .policy     (pol_r),
      .up         (up_r),
      .tok_in     (tok[g]),
      .tok_out    (tok[g+1])
    );
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r       <= POL_FCFS;
      start_track_r  <= '0;
      direction_up_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLICY:      policy_r       <= policy_t'(cfg_wdata[1:0]);
        REG_START_TRACK: start_track_r  <= cfg_wdata[TRACK_W-1:0];
        REG_DIRECTION:   direction_up_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // seek length for this decision: to the winner, or an edge run
  always_comb begin
    seek = '0;
    if (win.found) begin
      seek = (POS_W'(win.track) > head_r) ? (POS_W'(win.track) - head_r)
                                          : (head_r - POS_W'(win.track));
    end else if (pol_r == POL_SCAN) begin
      seek = up_r ? (TOP_POS - head_r) : head_r;
    end else begin
      seek = TOP_POS - head_r;
    end
  end

  always_comb begin
    // C-SCAN adds the return jump from the top edge to track zero
    sum = {2'b00, move_r} + {2'b00, seek};
    if (!win.found && (pol_r == POL_CSCAN)) begin
      sum = sum + {2'b00, TOP_POS};
    end
    if (sum > MOVE_SAT) begin
      sum = MOVE_SAT;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    emitted_nxt = emitted_r;
    srch_nxt    = srch_r;
    ovf_nxt     = ovf_r;
    up_nxt      = up_r;
    pol_nxt     = pol_r;
    head_nxt    = head_r;
    move_nxt    = move_r;
    clr         = 1'b0;
    mark_en     = 1'b0;
    out_valid_nxt = 1'b0;
    out_track_nxt = out_track_r;
    out_move_nxt  = out_move_r;
    out_final_nxt = out_final_r;
    out_ovf_nxt   = out_ovf_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (load_en) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_request) begin
            head_nxt    = POS_W'(start_track_r);
            move_nxt    = '0;
            emitted_nxt = '0;
            srch_nxt    = '0;
            pol_nxt     = policy_r;
            up_nxt      = (policy_r == POL_SCAN) ? direction_up_r : 1'b1;
            state_nxt   = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        srch_nxt = srch_r + CNT_W'(1);
        if (srch_r == SRCH_END) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        srch_nxt = '0;
        move_nxt = sum[MOVE_W-1:0];
        state_nxt = ST_SEARCH;
        if (win.found) begin
          head_nxt      = POS_W'(win.track);
          mark_en       = 1'b1;
          emitted_nxt   = emitted_inc;
          out_valid_nxt = 1'b1;
          out_track_nxt = win.track;
          out_move_nxt  = sum[MOVE_W-1:0];
          out_final_nxt = (emitted_inc == count_r);
          out_ovf_nxt   = ovf_r;
          if (emitted_inc == count_r) begin
            // batch done: empty the row for the next one
            clr       = 1'b1;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end else if (pol_r == POL_SCAN) begin
          head_nxt = up_r ? TOP_POS : '0;
          up_nxt   = !up_r;
        end else begin
          head_nxt = '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      emitted_r   <= '0;
      srch_r      <= '0;
      ovf_r       <= 1'b0;
      up_r        <= 1'b1;
      pol_r       <= POL_FCFS;
      head_r      <= '0;
      move_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      emitted_r   <= emitted_nxt;
      srch_r      <= srch_nxt;
      ovf_r       <= ovf_nxt;
      up_r        <= up_nxt;
      pol_r       <= pol_nxt;
      head_r      <= head_nxt;
      move_r      <= move_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_track_r <= out_track_nxt;
    out_move_r  <= out_move_nxt;
    out_final_r <= out_final_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_served_track    = out_track_r;
  assign out_movement_so_far = out_move_r;
  assign out_final_result    = out_final_r;
  assign out_overflowed      = out_ovf_r;

endmodule
